// ===== rtl/rig_pkg.sv =====
package rig_pkg;

  // Fixed field widths
  localparam int BASE_BITS = 12;
  localparam int FRAC_BITS = 32;
  localparam int AXIS_BITS = 3;
  localparam int BASE_MIN  = 2;

  // Control sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL_R,
    ST_MUL_S,
    ST_FRAC,
    ST_DONE
  } state_t;

  // Status of the fraction divider
  typedef struct packed {
    logic busy;
    logic done;
  } frac_stat_t;

  // Base register values after reset: the first eight primes
  function automatic logic [BASE_BITS-1:0] base_reset(input logic [AXIS_BITS-1:0] a);
    logic [BASE_BITS-1:0] b;
    case (a)
      3'd0:    b = 12'd2;
      3'd1:    b = 12'd3;
      3'd2:    b = 12'd5;
      3'd3:    b = 12'd7;
      3'd4:    b = 12'd11;
      3'd5:    b = 12'd13;
      3'd6:    b = 12'd17;
      3'd7:    b = 12'd19;
      default: b = 12'd2;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/rig_frac_div.sv =====
// Restoring divider: quot = floor(num * 2^FRAC_BITS / den), num < den.
// One quotient bit per cycle while busy; done is raised together with the last quotient bit.
module rig_frac_div #(
  parameter int DEN_BITS = 44
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [DEN_BITS-1:0]            num,
  input  logic [DEN_BITS-1:0]            den,
  output rig_pkg::frac_stat_t            stat,
  output logic [rig_pkg::FRAC_BITS-1:0]  quot
);

  localparam int CNT_W = $clog2(rig_pkg::FRAC_BITS);

  logic [DEN_BITS-1:0] rem;
  logic [DEN_BITS-1:0] den_q;
  logic [CNT_W-1:0]    cnt;
  logic                busy;
  logic                done;

  logic [DEN_BITS:0]   shifted;
  logic [DEN_BITS:0]   diff;
  logic                ge;

  // One trial subtraction per cycle
  assign shifted = {rem, 1'b0};
  assign ge      = shifted >= {1'b0, den_q};
  assign diff    = shifted - {1'b0, den_q};

  // Step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(rig_pkg::FRAC_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= num;
      den_q <= den;
    end else if (busy) begin
      rem  <= ge ? diff[DEN_BITS-1:0] : shifted[DEN_BITS-1:0];
      quot <= {quot[rig_pkg::FRAC_BITS-2:0], ge};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ===== rtl/radical_inverse_generator.sv =====
// One item in flight; index 0 or an axis at or above AXES goes straight to the output.
// The digit loop is a bit-serial divide by the base followed by two passes through one
// 44x12 multiplier, then a bit-serial fraction divide.
// Reset (rst, synchronous): sequencer idle, output empty, base registers 2,3,5,...,19.
module radical_inverse_generator #(
  parameter int AXES       = 8,
  parameter int INDEX_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [rig_pkg::AXIS_BITS-1:0]   cfg_index,
  input  logic [rig_pkg::BASE_BITS-1:0]   cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [rig_pkg::AXIS_BITS-1:0]   axis,
  input  logic [31:0]                     sample_index,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [rig_pkg::FRAC_BITS-1:0]   fraction
);

  localparam int BB         = rig_pkg::BASE_BITS;
  localparam int SCALE_BITS = INDEX_BITS + BB;
  localparam int LEN_W      = $clog2(INDEX_BITS + 1);
  localparam int POS_W      = $clog2(INDEX_BITS);
  localparam int SEL_W      = (AXES > 1) ? $clog2(AXES) : 1;

  rig_pkg::state_t state;
  rig_pkg::state_t state_next;

  logic [BB-1:0]         base_reg [AXES];
  logic [BB-1:0]         base_sel;
  logic [BB-1:0]         base_q;
  logic                  axis_ok;
  logic                  accept;
  logic                  zero_q;

  logic [INDEX_BITS-1:0] n_q;
  logic [INDEX_BITS-1:0] quo_q;
  logic [INDEX_BITS-1:0] quo_next;
  logic [LEN_W-1:0]      len_q;
  logic [LEN_W-1:0]      len_m1;
  logic [LEN_W-1:0]      lz_q;
  logic [LEN_W-1:0]      lz_next;
  logic                  lead_q;
  logic [POS_W-1:0]      pos_q;
  logic [BB-1:0]         rem_q;
  logic [BB:0]           rem_sh;
  logic [BB:0]           rem_diff;
  logic                  qbit;

  logic [SCALE_BITS-1:0]    mir_q;
  logic [SCALE_BITS-1:0]    scale_q;
  logic [SCALE_BITS-1:0]    mul_a;
  logic [SCALE_BITS+BB-1:0] prod;

  logic                          frac_start;
  rig_pkg::frac_stat_t           frac_stat;
  logic [rig_pkg::FRAC_BITS-1:0] frac_quot;
  logic                          load_out;

  assign accept = in_valid && !in_stall;

  // Base registers
  for (genvar i = 0; i < AXES; i++) begin : g_base
    always_ff @(posedge clk) begin
      if (rst) begin
        base_reg[i] <= rig_pkg::base_reset(rig_pkg::AXIS_BITS'(i));
      end else if (cfg_write && cfg_index == rig_pkg::AXIS_BITS'(i)) begin
        base_reg[i] <= cfg_data;
      end
    end
  end

  assign axis_ok  = {29'd0, axis} < 32'(AXES);
  assign base_sel = base_reg[axis[SEL_W-1:0]];

  // One bit of the divide by the base
  assign rem_sh   = {rem_q, n_q[pos_q]};
  assign qbit     = rem_sh >= {1'b0, base_q};
  assign rem_diff = rem_sh - {1'b0, base_q};
  assign quo_next = {quo_q[INDEX_BITS-2:0], qbit};
  assign lz_next  = lz_q + LEN_W'(lead_q && !qbit);
  assign len_m1   = len_q - LEN_W'(1);

  // Shared multiplier: mirrored value in ST_MUL_R, scale in ST_MUL_S
  assign mul_a = (state == rig_pkg::ST_MUL_R) ? mir_q : scale_q;
  assign prod  = mul_a * base_q;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rig_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and sequencer outputs
  always_comb begin
    state_next = state;
    frac_start = 1'b0;
    load_out   = 1'b0;
    in_stall   = (state != rig_pkg::ST_IDLE);
    case (state)
      rig_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (!axis_ok || sample_index[INDEX_BITS-1:0] == '0) begin
            state_next = rig_pkg::ST_DONE;
          end else begin
            state_next = rig_pkg::ST_DIV;
          end
        end
      end
      rig_pkg::ST_DIV: begin
        if (pos_q == '0) state_next = rig_pkg::ST_MUL_R;
      end
      rig_pkg::ST_MUL_R: begin
        state_next = rig_pkg::ST_MUL_S;
      end
      rig_pkg::ST_MUL_S: begin
        if (n_q == '0) begin
          frac_start = 1'b1;
          state_next = rig_pkg::ST_FRAC;
        end else begin
          state_next = rig_pkg::ST_DIV;
        end
      end
      rig_pkg::ST_FRAC: begin
        if (frac_stat.done) state_next = rig_pkg::ST_DONE;
      end
      rig_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = rig_pkg::ST_IDLE;
        end
      end
      default: state_next = rig_pkg::ST_IDLE;
    endcase
  end

  // Digit loop datapath
  always_ff @(posedge clk) begin
    case (state)
      rig_pkg::ST_IDLE: begin
        if (accept) begin
          zero_q  <= !axis_ok || sample_index[INDEX_BITS-1:0] == '0;
          base_q  <= (base_sel < BB'(rig_pkg::BASE_MIN)) ? BB'(rig_pkg::BASE_MIN) : base_sel;
          n_q     <= sample_index[INDEX_BITS-1:0];
          len_q   <= LEN_W'(INDEX_BITS);
          pos_q   <= POS_W'(INDEX_BITS - 1);
          rem_q   <= '0;
          quo_q   <= '0;
          lz_q    <= '0;
          lead_q  <= 1'b1;
          mir_q   <= '0;
          scale_q <= SCALE_BITS'(1);
        end
      end
      rig_pkg::ST_DIV: begin
        rem_q <= qbit ? rem_diff[BB-1:0] : rem_sh[BB-1:0];
        quo_q <= quo_next;
        lz_q  <= lz_next;
        if (qbit) lead_q <= 1'b0;
        pos_q <= pos_q - POS_W'(1);
        // last bit: quotient becomes the next index, trimmed length
        if (pos_q == '0) begin
          n_q   <= quo_next;
          len_q <= len_q - lz_next;
        end
      end
      rig_pkg::ST_MUL_R: begin
        mir_q <= prod[SCALE_BITS-1:0] + SCALE_BITS'(rem_q);
      end
      rig_pkg::ST_MUL_S: begin
        scale_q <= prod[SCALE_BITS-1:0];
        // set up the next digit
        pos_q   <= len_m1[POS_W-1:0];
        rem_q   <= '0;
        quo_q   <= '0;
        lz_q    <= '0;
        lead_q  <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Final fraction divide
  rig_frac_div #(
    .DEN_BITS (SCALE_BITS)
  ) u_frac_div (
    .clk   (clk),
    .rst   (rst),
    .start (frac_start),
    .num   (mir_q),
    .den   (prod[SCALE_BITS-1:0]),
    .stat  (frac_stat),
    .quot  (frac_quot)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (load_out) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) fraction <= zero_q ? '0 : frac_quot;
  end

endmodule

// ===== rtl/rig_checker.sv =====
module rig_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic [rig_pkg::AXIS_BITS-1:0]   axis,
  input logic [31:0]                     sample_index,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [rig_pkg::FRAC_BITS-1:0]   fraction
);

  // One item at a time: busy right after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in flight");

  // Index zero yields a zero fraction, through ST_DONE and the output register, when the output is free
  a_zero_index: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && sample_index == 32'd0 && !out_valid
      |=> ##1 (out_valid && fraction == '0))
    else $error("index zero did not give a zero fraction");

  // A new result only appears while the sequencer holds off input
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without work in progress");

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(fraction))
    else $error("stalled result beat changed");

endmodule

bind radical_inverse_generator rig_checker u_rig_checker (.*);

// ===== sim/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_AXES        = 8;
  localparam int RANDOM_PHASES   = 6;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int TAIL_CYCLES     = 700;

  typedef logic [rig_pkg::AXIS_BITS-1:0] axis_t;
  typedef logic [rig_pkg::BASE_BITS-1:0] base_t;
  typedef logic [rig_pkg::FRAC_BITS-1:0] frac_t;

  typedef struct packed {
    axis_t       ax;
    logic [31:0] idx;
  } sample_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  axis_t       cfg_index = '0;
  base_t       cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  axis_t       axis = '0;
  logic [31:0] sample_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  frac_t       fraction;

  // Testbench copy of the base registers
  base_t   axis_bases [NUM_AXES];
  sample_t sample_queue [$];
  frac_t   expected_fractions [$];

  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int accepted_beats = 0;
  int checked_beats = 0;
  int base_settings = 0;

  radical_inverse_generator i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .axis         (axis),
    .sample_index (sample_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .fraction     (fraction)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Effective radix: 0 and 1 fall back to 2
  function automatic logic [63:0] radix_of(axis_t ax);
    logic [63:0] b;
    b = 64'(axis_bases[ax]);
    if (b < 2) b = 2;
    return b;
  endfunction

  // Mirror the base-b digits of n and scale to Q0.32, rounded down
  function automatic frac_t radical_fraction(axis_t ax, logic [31:0] n);
    logic [63:0] b;
    logic [63:0] rest;
    logic [63:0] mirrored;
    logic [63:0] scale;
    logic [95:0] num;
    b = radix_of(ax);
    rest = 64'(n);
    mirrored = 0;
    scale = 1;
    while (rest != 0) begin
      mirrored = mirrored * b + (rest % b);
      scale = scale * b;
      rest = rest / b;
    end
    num = {mirrored, 32'b0};
    return frac_t'(num / 96'(scale));
  endfunction

  // Index mix: small values, values around powers of the base, near-max, full random
  function automatic logic [31:0] pick_index(axis_t ax);
    logic [63:0] b;
    logic [63:0] p;
    int          r;
    int          steps;
    b = radix_of(ax);
    r = $urandom_range(99);
    if (r < 15) return 32'($urandom_range(255));
    if (r < 40) begin
      p = b;
      steps = $urandom_range(31);
      repeat (steps) if (p * b <= 64'hFFFF_FFFF) p = p * b;
      p = p + 64'($urandom_range(2)) - 1;
      if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;
      return p[31:0];
    end
    if (r < 50) return 32'hFFFF_FFFF - 32'($urandom_range(15));
    return $urandom;
  endfunction

  // Driver: holds a beat until accepted, random gaps between beats
  always @(posedge clk) begin : drive
    sample_t beat;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_fractions.push_back(radical_fraction(axis, sample_index));
        accepted_beats++;
      end
      if (!in_valid || !in_stall) begin
        if (sample_queue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          beat = sample_queue.pop_front();
          in_valid <= 1'b1;
          axis <= beat.ax;
          sample_index <= beat.idx;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random backpressure, compare each result beat in order
  always @(posedge clk) begin : watch
    frac_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_fractions.size() == 0) begin
          $error("fraction: unexpected beat, actual %h", fraction);
          errors++;
        end else begin
          want = expected_fractions.pop_front();
          checked_beats++;
          if (fraction !== want) begin
            $error("fraction: expected %h actual %h", want, fraction);
            errors++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic set_idling(int send_pct, int recv_pct);
    @(posedge clk);
    send_gap_pct <= send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  // Write all base registers; only called while the block is idle
  task automatic load_bases(base_t vals [NUM_AXES]);
    for (int a = 0; a < NUM_AXES; a++) begin
      @(posedge clk);
      cfg_write <= 1'b1;
      cfg_index <= axis_t'(a);
      cfg_data <= vals[a];
      axis_bases[a] = vals[a];
    end
    @(posedge clk);
    cfg_write <= 1'b0;
    base_settings++;
  endtask

  task automatic queue_sample(int ax, logic [31:0] idx);
    sample_t s;
    s.ax = axis_t'(ax);
    s.idx = idx;
    sample_queue.push_back(s);
  endtask

  task automatic wait_idle();
    while (sample_queue.size() != 0 || in_valid || expected_fractions.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    #20_000_000;
    $display("radical_inverse_generator: mismatch");
    $finish;
  end

  initial begin : stimulus
    base_t reset_bases [NUM_AXES];
    base_t edge_bases [NUM_AXES];
    base_t rand_bases [NUM_AXES];
    int    r;
    int    a;

    reset_bases = '{12'd2, 12'd3, 12'd5, 12'd7, 12'd11, 12'd13, 12'd17, 12'd19};
    // below-two fallback, prime-range top, widest values, plain small bases
    edge_bases = '{12'd0, 12'd1, 12'd2309, 12'd4095, 12'd2310, 12'd2, 12'd2048, 12'd3};
    axis_bases = reset_bases;
    base_settings = 1;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    set_idling(19, 84);

    // Directed with the reset bases
    for (a = 0; a < NUM_AXES; a++) queue_sample(a, 32'hFFFF_FFFF);
    queue_sample(0, 32'h0000_0000);
    queue_sample(1, 32'h0000_0001);
    queue_sample(0, 32'h8000_0000);
    queue_sample(2, 32'd1220703125);   // exact power of five
    queue_sample(1, 32'd3486784400);   // 3^20 - 1, all digits maximal
    wait_idle();

    // Directed with extreme register values
    load_bases(edge_bases);
    for (a = 0; a < NUM_AXES; a++) queue_sample(a, 32'hFFFF_FFFF);
    queue_sample(3, 32'd16769025);     // 4095^2
    queue_sample(0, 32'h0000_0001);
    wait_idle();

    // Random phases: new bases each phase, idling mode steps through three settings
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == 2) set_idling(84, 19);
      if (ph == 4) set_idling(0, 0);
      for (a = 0; a < NUM_AXES; a++) begin
        r = $urandom_range(99);
        if (r < 10)      rand_bases[a] = base_t'($urandom_range(1));
        else if (r < 25) rand_bases[a] = base_t'($urandom_range(4095, 2310));
        else if (r < 35) rand_bases[a] = 12'd2;
        else if (r < 65) rand_bases[a] = base_t'($urandom_range(31, 2));
        else             rand_bases[a] = base_t'($urandom_range(2309, 2));
      end
      load_bases(rand_bases);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        a = $urandom_range(NUM_AXES - 1);
        queue_sample(a, pick_index(axis_t'(a)));
      end
      wait_idle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_fractions.size() != 0) begin
      $error("fraction: %0d expected beats never arrived", expected_fractions.size());
      errors++;
    end

    $display("Checked %0d of %0d index beats across %0d base settings on all axes,",
             checked_beats, accepted_beats, base_settings);
    $display("with sender and receiver idling swapped between phases, then none.");
    if (errors == 0) begin
      $display("radical_inverse_generator: match");
    end else begin
      $display("radical_inverse_generator: mismatch");
    end
    $finish;
  end

endmodule
